### sv/lkvc_pkg.sv
// Shared constants, types and sequencer states for the LRU key-value cache.
package lkvc_pkg;

   localparam int DATA_W      = 32;
   localparam int CAP_W       = 5;
   localparam int ENTRIES_DEF = 16;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_PROMOTE,
      ST_PROM_END
   } state_type;

   typedef struct packed {
      logic key_we;
      logic val_we;
      logic rank_we;
   } wr_ctl_type;

endpackage

### sv/lkvc_mem.sv
// Key, value and recency-rank memories with one shared registered read port.
module lkvc_mem #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF,
   parameter int IDX_W   = 4
) (
   input  logic                 clock,
   input  logic [IDX_W-1:0]     rd_addr,
   input  lkvc_pkg::wr_ctl_type wr_ctl,
   input  logic [IDX_W-1:0]     kv_wr_addr,
   input  logic [IDX_W-1:0]     rank_wr_addr,
   input  lkvc_pkg::data_type   key_wdata,
   input  lkvc_pkg::data_type   val_wdata,
   input  logic [IDX_W-1:0]     rank_wdata,
   output lkvc_pkg::data_type   key_rdata,
   output lkvc_pkg::data_type   val_rdata,
   output logic [IDX_W-1:0]     rank_rdata
);
   import lkvc_pkg::*;

   data_type         key_mem  [ENTRIES];
   data_type         val_mem  [ENTRIES];
   logic [IDX_W-1:0] rank_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_ctl.key_we) begin
         key_mem[kv_wr_addr] <= key_wdata;
      end
      if (wr_ctl.val_we) begin
         val_mem[kv_wr_addr] <= val_wdata;
      end
      if (wr_ctl.rank_we) begin
         rank_mem[rank_wr_addr] <= rank_wdata;
      end
   end

   always_ff @(posedge clock) begin
      key_rdata  <= key_mem[rd_addr];
      val_rdata  <= val_mem[rd_addr];
      rank_rdata <= rank_mem[rd_addr];
   end

endmodule

### sv/lru_key_value_cache.sv
// Top level: fully associative key-value cache with least-recently-used replacement.
//
// Requests arrive on the req_ stream: tuser selects get (0) or set (1), tdata carries
// the key and the value. A get returns one word on the rsp_ stream: tuser is the hit
// flag, tdata the stored value, or all ones on a miss. A set returns nothing.
// The csr_ channel writes the capacity (0 acts as 1, above ENTRIES acts as ENTRIES);
// it is always ready. The user must see that it is written only while no request is
// in flight; the block itself does not enforce this. One request is handled at a
// time. Each starts with a scan of the key and rank memories through their single
// read port (match, oldest and free slot), followed on hits and sets by the rank
// update pass.
// A get response is registered, so the next request is taken while it waits; if the
// previous response is still not taken when a new get finishes its scan, the block
// holds until rsp_tready. Reset clears all valid bits, the occupancy and the capacity
// to 16; the stores themselves are not cleared.
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [63:0]              req_tdata,   // key[31:0], value[63:32]
   input  logic                     req_tuser,   // func
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,   // read_value[31:0]
   output logic                     rsp_tuser,   // hit
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_data
);
   import lkvc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             issue_scan, issue_prom, rsp_load, kv_write;

   logic             pipe_vld_ff, pipe_prom_ff;
   logic [IDX_W-1:0] pipe_idx_ff;

   logic             req_func_ff;
   data_type         req_key_ff, req_val_ff;

   logic             found_ff, old_found_ff, free_found_ff;
   logic [IDX_W-1:0] match_idx_ff, match_rank_ff, old_idx_ff, old_rank_ff, free_idx_ff;
   data_type         match_val_ff;

   logic [IDX_W-1:0] tgt_idx_ff, tgt_rank_ff, tgt_idx, tgt_rank;
   logic             new_slot;

   logic [ENTRIES-1:0] valid_ff;
   logic [OCC_W-1:0]   occ_ff;
   logic [CAP_W-1:0]   capacity_ff;

   logic             rsp_valid_ff, rsp_hit_ff;
   data_type         rsp_val_ff;

   data_type         key_rdata, val_rdata;
   logic [IDX_W-1:0] rank_rdata, rank_wdata;
   wr_ctl_type       wr_ctl;

   logic [CMP_W-1:0] cap_ext, eff_cap;
   logic             occ_full, rsp_free, pipe_valid_bit, is_tgt;

   lkvc_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock        (clock),
      .rd_addr      (addr_ff),
      .wr_ctl       (wr_ctl),
      .kv_wr_addr   (tgt_idx),
      .rank_wr_addr (pipe_idx_ff),
      .key_wdata    (req_key_ff),
      .val_wdata    (req_val_ff),
      .rank_wdata   (rank_wdata),
      .key_rdata    (key_rdata),
      .val_rdata    (val_rdata),
      .rank_rdata   (rank_rdata)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign cap_ext  = CMP_W'(capacity_ff);
   assign eff_cap  = (cap_ext == '0) ? CMP_W'(1) :
                     (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign occ_full = CMP_W'(occ_ff) >= eff_cap;

   always_comb begin
      new_slot = 1'b0;
      if (found_ff) begin
         tgt_idx  = match_idx_ff;
         tgt_rank = match_rank_ff;
      end else if (occ_full || !free_found_ff) begin
         tgt_idx  = old_idx_ff;
         tgt_rank = old_rank_ff;
      end else begin
         tgt_idx  = free_idx_ff;
         tgt_rank = IDX_W'(occ_ff);
         new_slot = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      req_tready = 1'b0;
      issue_scan = 1'b0;
      issue_prom = 1'b0;
      rsp_load   = 1'b0;
      kv_write   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue_scan = 1'b1;
            addr_in    = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (req_func_ff == FUNC_GET) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = found_ff ? ST_PROMOTE : ST_IDLE;
               end
            end else begin
               kv_write = 1'b1;
               state_in = ST_PROMOTE;
            end
         end
         ST_PROMOTE: begin
            issue_prom = 1'b1;
            addr_in    = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_PROM_END;
            end
         end
         ST_PROM_END: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff  <= 1'b0;
         pipe_prom_ff <= 1'b0;
      end else begin
         pipe_vld_ff  <= issue_scan || issue_prom;
         pipe_prom_ff <= issue_prom;
      end
      pipe_idx_ff <= addr_ff;
   end

   assign pipe_valid_bit = valid_ff[pipe_idx_ff];
   assign is_tgt         = pipe_idx_ff == tgt_idx_ff;

   always_comb begin
      wr_ctl.key_we  = kv_write && !found_ff;
      wr_ctl.val_we  = kv_write;
      wr_ctl.rank_we = pipe_vld_ff && pipe_prom_ff &&
                       (is_tgt || (pipe_valid_bit && rank_rdata < tgt_rank_ff));
      rank_wdata     = is_tgt ? '0 : IDX_W'(rank_rdata + 1'b1);
   end

   // request latch and scan results
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_func_ff <= req_tuser;
         req_key_ff  <= req_tdata[31:0];
         req_val_ff  <= req_tdata[63:32];
      end
      if (reset || (req_tvalid && req_tready)) begin
         found_ff      <= 1'b0;
         old_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (pipe_vld_ff && !pipe_prom_ff) begin
         if (pipe_valid_bit && key_rdata == req_key_ff && !found_ff) begin
            found_ff      <= 1'b1;
            match_idx_ff  <= pipe_idx_ff;
            match_rank_ff <= rank_rdata;
            match_val_ff  <= val_rdata;
         end
         if (pipe_valid_bit && (!old_found_ff || rank_rdata >= old_rank_ff)) begin
            old_found_ff <= 1'b1;
            old_idx_ff   <= pipe_idx_ff;
            old_rank_ff  <= rank_rdata;
         end
         if (!pipe_valid_bit && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= pipe_idx_ff;
         end
      end
      if (state_ff == ST_DECIDE) begin
         tgt_idx_ff  <= tgt_idx;
         tgt_rank_ff <= tgt_rank;
      end
   end

   // occupancy, capacity and response
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         if (kv_write && !found_ff && new_slot) begin
            valid_ff[tgt_idx] <= 1'b1;
            occ_ff            <= occ_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_hit_ff <= found_ff;
         rsp_val_ff <= found_ff ? match_val_ff : MISS_VALUE;
      end
   end

endmodule
